### rtl/tljik_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the two-link IK step block.
// No dependencies; every other file imports this package.
package tljik_pkg;

   localparam int DATA_WIDTH = 16;
   localparam int FRAC_BITS  = 12;
   localparam int CW         = 34;   // CORDIC datapath width, Q2.30 with headroom
   localparam int NUM_W      = 48;   // divider numerator width
   localparam int DEN_W      = 45;   // divider denominator width

   localparam logic signed [DATA_WIDTH-1:0] PI_Q     = 16'sd12868;
   localparam logic signed [18:0]           SPAN_Q   = 19'sd25736;
   localparam logic signed [DATA_WIDTH-1:0] Q1_RESET = -16'sd1608;
   localparam logic signed [DATA_WIDTH-1:0] Q2_RESET = 16'sd9651;
   localparam logic signed [CW-1:0] PI_Q30      = 34'sd3373259426;
   localparam logic signed [CW-1:0] HALF_PI_Q30 = 34'sd1686629713;
   localparam logic signed [CW-1:0] CORDIC_K    = 34'sd652032874;
   localparam logic [4:0] CORDIC_LAST = 5'd29;
   localparam logic [3:0] MUL_LAST    = 4'd10;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CORDIC_GO, ST_CORDIC, ST_MUL, ST_DIV1_GO, ST_DIV1,
      ST_DIV2_GO, ST_DIV2, ST_UPDATE, ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      REG_LINK2, REG_STEPS, REG_HALF_SIDE, REG_THRESHOLD
   } csr_index_type;

   // Arctangent of 2^-i in Q2.30; beyond the table the angle equals 2^-i.
   function automatic logic signed [CW-1:0] atan_entry(input logic [4:0] i);
      logic signed [CW-1:0] v;
      case (i)
         5'd0: v = 34'sd843314857;
         5'd1: v = 34'sd497837830;
         5'd2: v = 34'sd263043837;
         5'd3: v = 34'sd133525159;
         5'd4: v = 34'sd67021687;
         5'd5: v = 34'sd33543516;
         5'd6: v = 34'sd16775851;
         5'd7: v = 34'sd8388437;
         5'd8: v = 34'sd4194283;
         5'd9: v = 34'sd2097149;
         default: v = $signed({{(CW-1){1'b0}}, 1'b1} << (5'd30 - i));
      endcase
      return v;
   endfunction

   // Wraps an angle into [-PI, PI); the input never lies more than two spans out.
   function automatic logic signed [DATA_WIDTH-1:0] wrap_angle(input logic signed [17:0] a);
      logic signed [18:0] t;
      t = 19'(a) + 19'(PI_Q);
      if (t < 0) t = t + SPAN_Q;
      if (t < 0) t = t + SPAN_Q;
      if (t >= SPAN_Q) t = t - SPAN_Q;
      if (t >= SPAN_Q) t = t - SPAN_Q;
      t = t - 19'(PI_Q);
      return t[DATA_WIDTH-1:0];
   endfunction

endpackage

### rtl/tljik_cordic.sv
`timescale 1ns / 1ps
// Iterative rotation-mode CORDIC giving sine and cosine of a wrapped angle.
// Depends on tljik_pkg for widths, the arctangent table and constants.
module tljik_cordic import tljik_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic signed [DATA_WIDTH-1:0] angle,
   output logic                         done,
   output logic signed [DATA_WIDTH-1:0] sin_out,
   output logic signed [DATA_WIDTH-1:0] cos_out
);

   logic signed [CW-1:0] x_ff, y_ff, z_ff, z_start, x_fix, y_fix, x_rnd, y_rnd;
   logic [4:0] iter_ff;
   logic       run_ff, flip_ff, done_ff;

   assign z_start = CW'(angle) <<< (30 - FRAC_BITS);

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff  <= 1'b1;
            iter_ff <= '0;
         end else if (run_ff) begin
            iter_ff <= iter_ff + 5'd1;
            if (iter_ff == CORDIC_LAST) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         x_ff <= CORDIC_K;
         y_ff <= '0;
         if (z_start > HALF_PI_Q30) begin
            z_ff    <= z_start - PI_Q30;
            flip_ff <= 1'b1;
         end else if (z_start < -HALF_PI_Q30) begin
            z_ff    <= z_start + PI_Q30;
            flip_ff <= 1'b1;
         end else begin
            z_ff    <= z_start;
            flip_ff <= 1'b0;
         end
      end else if (run_ff) begin
         if (z_ff >= 0) begin
            x_ff <= x_ff - (y_ff >>> iter_ff);
            y_ff <= y_ff + (x_ff >>> iter_ff);
            z_ff <= z_ff - atan_entry(iter_ff);
         end else begin
            x_ff <= x_ff + (y_ff >>> iter_ff);
            y_ff <= y_ff - (x_ff >>> iter_ff);
            z_ff <= z_ff + atan_entry(iter_ff);
         end
      end
   end

   assign x_fix = flip_ff ? -x_ff : x_ff;
   assign y_fix = flip_ff ? -y_ff : y_ff;
   assign x_rnd = (x_fix + (CW'(1) <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
   assign y_rnd = (y_fix + (CW'(1) <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
   assign cos_out = x_rnd[DATA_WIDTH-1:0];
   assign sin_out = y_rnd[DATA_WIDTH-1:0];
   assign done    = done_ff;

endmodule

### rtl/tljik_div.sv
`timescale 1ns / 1ps
// Restoring divider: num * 2^FRAC_BITS / den, truncated and saturated.
// Depends on tljik_pkg for widths; one quotient bit per cycle.
module tljik_div import tljik_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic signed [NUM_W-1:0]      num,
   input  logic signed [DEN_W-1:0]      den,
   output logic                         done,
   output logic signed [DATA_WIDTH-1:0] quotient
);

   logic [NUM_W-1:0] n_mag;
   logic [DEN_W-1:0] d_mag, d_ff;
   logic [DEN_W:0]   r_ff, r_shift;
   logic [DATA_WIDTH-1:0] bits_ff, q_ff;
   logic [3:0] cnt_ff;
   logic run_ff, done_ff, neg_ff, sat_ff;

   assign n_mag   = (num < 0) ? NUM_W'(-num) : NUM_W'(num);
   assign d_mag   = (den < 0) ? DEN_W'(-den) : DEN_W'(den);
   assign r_shift = {r_ff[DEN_W-1:0], bits_ff[DATA_WIDTH-1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + 4'd1;
            if (cnt_ff == 4'hF) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         neg_ff  <= (num < 0) != (den < 0);
         sat_ff  <= {1'b0, n_mag} >= {d_mag, 4'b0000};
         d_ff    <= d_mag;
         r_ff    <= (DEN_W+1)'(n_mag >> 4);
         bits_ff <= {n_mag[3:0], {(DATA_WIDTH-4){1'b0}}};
         q_ff    <= '0;
      end else if (run_ff) begin
         bits_ff <= bits_ff << 1;
         if (r_shift >= {1'b0, d_ff}) begin
            r_ff <= r_shift - {1'b0, d_ff};
            q_ff <= {q_ff[DATA_WIDTH-2:0], 1'b1};
         end else begin
            r_ff <= r_shift;
            q_ff <= {q_ff[DATA_WIDTH-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      if (neg_ff) begin
         if (sat_ff || q_ff > {1'b1, {(DATA_WIDTH-1){1'b0}}})
            quotient = {1'b1, {(DATA_WIDTH-1){1'b0}}};
         else
            quotient = -$signed(q_ff);
      end else begin
         if (sat_ff || q_ff[DATA_WIDTH-1])
            quotient = {1'b0, {(DATA_WIDTH-1){1'b1}}};
         else
            quotient = $signed(q_ff);
      end
   end

   assign done = done_ff;

endmodule

### rtl/two_link_jacobian_ik_step.sv
`timescale 1ns / 1ps
// Sequence from accepting a word to a valid result word: a start state, the CORDIC
// (30 iterations), 11 passes through the shared multiplier, two restoring divisions
// (each with a start state, 16 quotient bits and done), and one update state.
// No new word is taken until the result word has been accepted, so result stalls
// delay the next word. Reset (synchronous, active high) restores register defaults,
// the starting joint angles, step count and corner.
module two_link_jacobian_ik_step import tljik_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [15:0]           req_measured_y,
   input  logic signed [15:0]           req_measured_z,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [14:0]           rsp_joint_one_angle,
   output logic signed [14:0]           rsp_joint_two_angle,
   output logic                         rsp_singular,
   output logic [1:0]                   rsp_target_corner,
   output logic                         rsp_segment_end,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  csr_index_type                csr_index,
   input  logic [14:0]                  csr_wdata
);

   state_type state_ff, state_in;
   logic [14:0] link2_ff, half_ff, thresh_ff;
   logic [11:0] steps_cfg_ff, step_ff;
   logic [1:0]  corner_ff;
   logic signed [DATA_WIDTH-1:0] q1_ff, q2_ff, sin_w, cos_w, sin_ff, cos_ff, quo_w, dq1_ff;
   logic signed [15:0] ey_ff, ez_ff;
   logic signed [16:0] j11, j21, j12_ff, j22_ff;
   logic signed [17:0] ty_d, tz_d;
   logic signed [33:0] det_ff, pa_ff;
   logic signed [29:0] dy_ff, dz_ff;
   logic signed [NUM_W-1:0] num1_ff, num2_ff;
   logic signed [DEN_W-1:0] den_ff;
   logic signed [33:0] mul_a;
   logic signed [30:0] mul_b;
   logic signed [64:0] mul_p, j_rnd;
   logic [3:0]  mstep_ff;
   logic [11:0] steps, eff;
   logic        seg_end, sing, cordic_go, cordic_done, div_go, div_done;
   logic signed [33:0] abs_det;
   logic signed [15:0] h_s;

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         link2_ff     <= 15'd3686;
         steps_cfg_ff <= 12'd64;
         half_ff      <= 15'd2048;
         thresh_ff    <= 15'd16;
      end else if (csr_valid) begin
         case (csr_index)
            REG_LINK2:     link2_ff     <= csr_wdata;
            REG_STEPS:     steps_cfg_ff <= csr_wdata[11:0];
            REG_HALF_SIDE: half_ff      <= csr_wdata;
            REG_THRESHOLD: thresh_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Step and corner bookkeeping.
   assign steps   = (steps_cfg_ff == 12'd0) ? 12'd1 : steps_cfg_ff;
   assign seg_end = step_ff >= steps - 12'd1;
   assign eff     = seg_end ? steps - 12'd1 : step_ff;
   assign h_s     = $signed({1'b0, half_ff});
   assign ty_d    = ((corner_ff == 2'd1 || corner_ff == 2'd2) ? 18'(h_s) : -18'(h_s))
                    - 18'(ey_ff);
   assign tz_d    = (corner_ff[1] ? 18'(h_s) : -18'(h_s)) - 18'(ez_ff);
   assign j11     = -17'(ez_ff);
   assign j21     = 17'(ey_ff);
   assign abs_det = (det_ff < 0) ? -det_ff : det_ff;
   assign sing    = (det_ff == 0) || (abs_det < 34'($signed({1'b0, thresh_ff})) <<< FRAC_BITS);

   // Shared multiplier; the operand pair is chosen by the multiply step.
   always_comb begin
      case (mstep_ff)
         4'd0:    begin mul_a = 34'($signed({1'b0, link2_ff})); mul_b = 31'(cos_ff); end
         4'd1:    begin mul_a = 34'($signed({1'b0, link2_ff})); mul_b = 31'(sin_ff); end
         4'd2:    begin mul_a = 34'(j11);    mul_b = 31'(j22_ff); end
         4'd3:    begin mul_a = 34'(j12_ff); mul_b = 31'(j21);    end
         4'd4:    begin mul_a = 34'($signed({1'b0, eff})); mul_b = 31'(ty_d); end
         4'd5:    begin mul_a = 34'($signed({1'b0, eff})); mul_b = 31'(tz_d); end
         4'd6:    begin mul_a = 34'(j22_ff); mul_b = 31'(dy_ff);  end
         4'd7:    begin mul_a = 34'(j12_ff); mul_b = 31'(dz_ff);  end
         4'd8:    begin mul_a = 34'(j11);    mul_b = 31'(dz_ff);  end
         4'd9:    begin mul_a = 34'(j21);    mul_b = 31'(dy_ff);  end
         4'd10:   begin mul_a = det_ff;      mul_b = 31'($signed({1'b0, steps})); end
         default: begin mul_a = '0;          mul_b = '0;          end
      endcase
   end

   assign mul_p = mul_a * mul_b;
   assign j_rnd = (mul_p + (65'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid) begin
         ey_ff <= req_measured_y;
         ez_ff <= req_measured_z;
      end
      if (cordic_done) begin
         sin_ff <= sin_w;
         cos_ff <= cos_w;
      end
      if (state_ff == ST_DIV1 && div_done)
         dq1_ff <= quo_w;
      if (state_ff == ST_MUL) begin
         case (mstep_ff)
            4'd0:    j12_ff  <= -j_rnd[16:0];
            4'd1:    j22_ff  <= -j_rnd[16:0];
            4'd2:    pa_ff   <= mul_p[33:0];
            4'd3:    det_ff  <= pa_ff - mul_p[33:0];
            4'd4:    dy_ff   <= mul_p[29:0];
            4'd5:    dz_ff   <= mul_p[29:0];
            4'd6:    num1_ff <= mul_p[NUM_W-1:0];
            4'd7:    num1_ff <= num1_ff - mul_p[NUM_W-1:0];
            4'd8:    num2_ff <= mul_p[NUM_W-1:0];
            4'd9:    num2_ff <= num2_ff - mul_p[NUM_W-1:0];
            4'd10:   den_ff  <= mul_p[DEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         mstep_ff  <= '0;
         q1_ff     <= Q1_RESET;
         q2_ff     <= Q2_RESET;
         step_ff   <= '0;
         corner_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_MUL)
            mstep_ff <= mstep_ff + 4'd1;
         else
            mstep_ff <= '0;
         if (state_ff == ST_UPDATE) begin
            q1_ff <= wrap_angle(18'(q1_ff) + (sing ? 18'sd0 : 18'(dq1_ff)));
            q2_ff <= wrap_angle(18'(q2_ff) + (sing ? 18'sd0 : 18'(quo_w)));
            if (seg_end) begin
               step_ff   <= '0;
               corner_ff <= corner_ff + 2'd1;
            end else begin
               step_ff <= step_ff + 12'd1;
            end
         end
      end
   end

   // Result word; quo_w still holds the second quotient during the update state.
   always_ff @(posedge clock) begin
      if (state_ff == ST_UPDATE) begin
         rsp_joint_one_angle <= 15'(wrap_angle(18'(q1_ff) + (sing ? 18'sd0 : 18'(dq1_ff))));
         rsp_joint_two_angle <= 15'(wrap_angle(18'(q2_ff) + (sing ? 18'sd0 : 18'(quo_w))));
         rsp_singular        <= sing;
         rsp_target_corner   <= corner_ff;
         rsp_segment_end     <= seg_end;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:      if (req_valid) state_in = ST_CORDIC_GO;
         ST_CORDIC_GO: state_in = ST_CORDIC;
         ST_CORDIC:    if (cordic_done) state_in = ST_MUL;
         ST_MUL:       if (mstep_ff == MUL_LAST) state_in = ST_DIV1_GO;
         ST_DIV1_GO:   state_in = ST_DIV1;
         ST_DIV1:      if (div_done) state_in = ST_DIV2_GO;
         ST_DIV2_GO:   state_in = ST_DIV2;
         ST_DIV2:      if (div_done) state_in = ST_UPDATE;
         ST_UPDATE:    state_in = ST_OUT;
         ST_OUT:       if (rsp_ready) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cordic_go = 1'b0;
      div_go    = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_CORDIC_GO: cordic_go = 1'b1;
         ST_DIV1_GO:   div_go    = 1'b1;
         ST_DIV2_GO:   div_go    = 1'b1;
         ST_OUT:       rsp_valid = 1'b1;
         default: ;
      endcase
   end

   tljik_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cordic_go),
      .angle   (wrap_angle(18'(q1_ff) + 18'(q2_ff))),
      .done    (cordic_done),
      .sin_out (sin_w),
      .cos_out (cos_w)
   );

   tljik_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_go),
      .num      ((state_ff == ST_DIV1_GO) ? num1_ff : num2_ff),
      .den      (den_ff),
      .done     (div_done),
      .quotient (quo_w)
   );

   a_one_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input taken while a result word is pending");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("block still ready after accepting a word");

   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_joint_one_angle >= -15'sd12868 && rsp_joint_one_angle <= 15'sd12867
                  && rsp_joint_two_angle >= -15'sd12868 && rsp_joint_two_angle <= 15'sd12867))
      else $error("joint angle outside the wrapped range");

endmodule
